FILE: rtl/core/pnc_pkg.sv
package pnc_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  // product times four, the Q-format alignment of sample*gain/peak*0.5
  localparam int DIVD_W   = PROD_W + 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd2;

  localparam logic [GAIN_W-1:0]          GAIN_RESET  = 16'd4096;
  localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = -16'sd32768;

  // input actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       blank;
    logic                       final_load;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] scaled_sample;
    logic                       last_out;
  } result_t;

  typedef struct packed {
    logic                       blank;
    logic signed [SAMPLE_W-1:0] sample;
  } entry_t;

endpackage

FILE: rtl/core/pnc_store.sv
module pnc_store import pnc_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/pnc_mul.sv
module pnc_mul import pnc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] mcand,
  input  logic [GAIN_W-1:0]   mplier,
  output logic                done,
  output logic [PROD_W-1:0]   product
);

  localparam int CNT_BITS = $clog2(GAIN_W);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [SAMPLE_W-1:0] a;
  logic [SAMPLE_W-1:0] hi;
  logic [GAIN_W-1:0]   lo;
  logic [SAMPLE_W:0]   sum;

  // one multiplier bit per cycle, partial sum shifts right
  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, a} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(GAIN_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a  <= mcand;
      hi <= '0;
      lo <= mplier;
    end else if (busy) begin
      hi <= sum[SAMPLE_W:1];
      lo <= {sum[0], lo[GAIN_W-1:1]};
    end
  end

endmodule

FILE: rtl/core/pnc_div.sv
module pnc_div import pnc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIVD_W-1:0]   dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  output logic                done,
  output logic [DIVD_W-1:0]   quotient
);

  localparam int CNT_BITS = $clog2(DIVD_W);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [SAMPLE_W-1:0] dsr;
  logic [SAMPLE_W-1:0] rem;
  logic [DIVD_W-1:0]   dq;     // dividend bits out on top, quotient bits in at bottom
  logic [SAMPLE_W:0]   trial;
  logic                fits;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem, dq[DIVD_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits SAMPLE_W bits
      rem <= fits ? SAMPLE_W'(trial - {1'b0, dsr}) : trial[SAMPLE_W-1:0];
      dq  <= {dq[DIVD_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/core/peak_normalize_and_clip.sv
// Channel   Direction  Handshake                  Beat
// item      in         item_valid / item_stall    item_t: action, sample, blank, final_load
// result    out        result_valid / result_stall result_t: scaled_sample, last_out
// config    in         wr_en (no wait)            wr_index, wr_data
//
// Load beats never raise item_stall. After a drain beat item_stall stays high through
// the memory read, 16 multiplier steps, one handoff, 34 divider steps, one handoff
// and the output load. A blank entry or a zero peak skips both units and the
// divider handoffs, going from the memory read straight to the output load.
// rst is synchronous, active high; it clears counters, peak and handshake state
// but not the sample memory. A finished result waits in the output register while
// the next beat is taken; a drain stays stalled in its last step while it is full.
module peak_normalize_and_clip import pnc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SAMPLE_W-1:0]  wr_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  // configuration
  logic [GAIN_W-1:0]          volume_gain;
  logic signed [SAMPLE_W-1:0] upper_limit;
  logic signed [SAMPLE_W-1:0] lower_limit;

  // set state
  logic [SAMPLE_W-1:0] peak;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    rd_idx;
  logic                complete;
  logic [2:0]          state;

  // per-drain working registers
  logic [SAMPLE_W-1:0] peak_w;
  logic                last_w;
  logic                blank_w;
  logic                neg_w;
  logic                zero_w;

  logic accept;
  logic do_load;
  logic do_store;
  logic do_drain;
  logic drain_last;
  logic out_free;

  logic [SAMPLE_W-1:0] load_mag;
  logic [SAMPLE_W-1:0] rd_mag;
  logic [CNT_W-1:0]    rd_idx_inc;

  entry_t              wr_entry;
  entry_t              rd_entry;

  logic                mul_start;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_p;
  logic                div_done;
  logic [DIVD_W-1:0]   div_q;

  logic [DIVD_W-1:0]          q_use;
  logic                       neg_use;
  logic                       sat;
  logic signed [SAMPLE_W+1:0] v;
  logic signed [SAMPLE_W+1:0] up_ext;
  logic signed [SAMPLE_W+1:0] lo_ext;
  logic                       above;
  logic                       below;
  logic signed [SAMPLE_W-1:0] clipped;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  // loads are ignored once the set is closed; full buffer drops the sample
  assign do_load  = accept && (item.action == ACT_LOAD) && !complete;
  assign do_store = do_load && (count < CNT_W'(BUFFER_DEPTH));
  // drains only count once the set is closed and entries remain
  assign do_drain = accept && (item.action == ACT_DRAIN) && complete && (rd_idx < count);

  assign rd_idx_inc = rd_idx + 1'b1;
  assign drain_last = (rd_idx_inc >= count);

  assign load_mag = item.sample[SAMPLE_W-1] ? SAMPLE_W'(-item.sample) : item.sample;

  assign wr_entry.blank  = item.blank;
  assign wr_entry.sample = item.sample;

  pnc_store u_store (
    .clk     (clk),
    .wr_en   (do_store),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (do_drain),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_entry)
  );

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_gain <= GAIN_RESET;
      upper_limit <= UPPER_RESET;
      lower_limit <= LOWER_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_VOLUME_GAIN: volume_gain <= wr_data;
        REG_UPPER_LIMIT: upper_limit <= wr_data;
        REG_LOWER_LIMIT: lower_limit <= wr_data;
        default: ;
      endcase
    end
  end

  // set bookkeeping: count, peak, read pointer, closed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      peak     <= '0;
      count    <= '0;
      rd_idx   <= '0;
      complete <= 1'b0;
    end else if (do_drain) begin
      rd_idx <= rd_idx_inc;
      if (drain_last) begin
        peak     <= '0;
        count    <= '0;
        rd_idx   <= '0;
        complete <= 1'b0;
      end
    end else if (do_load) begin
      if (do_store) begin
        count <= count + 1'b1;
        if (!item.blank && (load_mag > peak)) begin
          peak <= load_mag;
        end
      end
      if (item.final_load && (do_store || (count != '0))) begin
        complete <= 1'b1;
      end
    end
  end

  // drain sequencer
  assign rd_mag    = rd_entry.sample[SAMPLE_W-1] ? SAMPLE_W'(-rd_entry.sample)
                                                 : rd_entry.sample;
  assign mul_start = (state == ST_RD) && !rd_entry.blank && (peak_w != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (do_drain) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= mul_start ? ST_MUL : ST_FIN;
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_drain) begin
      peak_w <= peak;
      last_w <= drain_last;
    end
    if (state == ST_RD) begin
      blank_w <= rd_entry.blank;
      neg_w   <= rd_entry.sample[SAMPLE_W-1];
      // non-blank sample over a zero peak: plain zero, no clip
      zero_w  <= !rd_entry.blank && (peak_w == '0);
    end
  end

  pnc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (rd_mag),
    .mplier  (volume_gain),
    .done    (mul_done),
    .product (mul_p)
  );

  pnc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == ST_MUL) && mul_done),
    .dividend ({mul_p, 2'b00}),
    .divisor  (peak_w),
    .done     (div_done),
    .quotient (div_q)
  );

  // sign, saturate and clip; a blank entry clips a zero
  assign q_use   = blank_w ? '0 : div_q;
  assign neg_use = neg_w && !blank_w;
  assign sat     = |q_use[DIVD_W-1:SAMPLE_W];
  assign v       = neg_use ? -$signed({2'b00, q_use[SAMPLE_W-1:0]})
                           :  $signed({2'b00, q_use[SAMPLE_W-1:0]});
  assign up_ext  = (SAMPLE_W+2)'(upper_limit);
  assign lo_ext  = (SAMPLE_W+2)'(lower_limit);
  // magnitude past 16 bits lies beyond either limit in its sign's direction
  assign above   = sat ? !neg_use : (v > up_ext);
  assign below   = sat ?  neg_use : (v < lo_ext);

  always_comb begin
    if (zero_w) begin
      clipped = '0;
    end else if (above) begin
      clipped = upper_limit;
    end else if (below) begin
      clipped = lower_limit;
    end else begin
      clipped = v[SAMPLE_W-1:0];
    end
  end

  // output register
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      result.scaled_sample <= clipped;
      result.last_out      <= last_w;
    end
  end

endmodule
